### hdl/sktb_pkg.sv
package sktb_pkg;

  localparam int KEY_W = 32;
  localparam int POS_W = 8;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic                    last;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } rsp_t;

  // One sorting cell: a key and whether it holds a key of the current set.
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } cell_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_COPY,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

### hdl/sktb_ram.sv
module sktb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/sktb_cell.sv
module sktb_cell #(
  parameter bit PARITY = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  sktb_pkg::cell_ctl_t ctl,
  input  sktb_pkg::cell_t     left,
  input  sktb_pkg::cell_t     right,
  output sktb_pkg::cell_t     q
);
  import sktb_pkg::*;

  cell_t q_next;
  logic  swap_right;
  logic  swap_left;

  // Both cells of a pair evaluate the same compare, so they swap together.
  assign swap_right = q.valid && right.valid && (q.key > right.key);
  assign swap_left  = left.valid && q.valid && (left.key > q.key);

  always_comb begin
    q_next = q;
    unique case (ctl.op)
      CELL_HOLD:      q_next = q;
      CELL_SHIFT_IN:  q_next = left;
      CELL_SHIFT_OUT: q_next = right;
      CELL_SORT: begin
        if (ctl.phase == PARITY) begin
          if (swap_right) begin
            q_next = right;
          end
        end else begin
          if (swap_left) begin
            q_next = left;
          end
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
    q.key <= q_next.key;
  end

endmodule

### hdl/sorted_key_table_search_core.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid, req_ready | req (mode, key, last)
// rsp     | out       | rsp_valid, rsp_ready | rsp (found, position)
//
// A load transaction is accepted while idle; one with last set then holds req_ready low while
// the cell row sorts the set by odd-even transposition passes, then while cell 0 drains it in
// order into the key memory. Each search probe is a registered read, then a compare; a search
// makes at most floor(log2 N)+1 probes for N stored keys before its response is posted.
// Reset clears the cell valid bits and the control state; the key memory needs no clearing.
// A stalled rsp holds its result; the next req transaction is accepted meanwhile once idle.
module sorted_key_table_search_core #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sktb_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sktb_pkg::rsp_t rsp
);
  import sktb_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SW     = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_t state, state_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic set_closed, set_closed_next;
  logic [CNT_W-1:0] step, step_next;
  logic signed [SW-1:0] low, low_next;
  logic signed [SW-1:0] high, high_next;
  logic [ADDR_W-1:0] mid, mid_next;
  logic signed [KEY_W-1:0] search_key, search_key_next;
  logic found_q, found_next;
  logic rsp_valid_next;
  rsp_t rsp_next;

  logic [CNT_W-1:0] cnt_eff;
  logic signed [SW-1:0] diff;
  logic signed [SW-1:0] mid_sum;
  logic [ADDR_W-1:0] mid_calc;
  logic signed [SW-1:0] mid_s;
  logic [ADDR_W+POS_W-1:0] mid_ext;

  cell_ctl_t cell_ctl;
  cell_t cells [TABLE_DEPTH];
  cell_t entry_cell;
  cell_t empty_cell;

  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;
  logic signed [KEY_W-1:0] rd_key;

  assign entry_cell.valid = (cell_ctl.op == CELL_SHIFT_IN);
  assign entry_cell.key   = req.key;
  assign empty_cell.valid = 1'b0;
  assign empty_cell.key   = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_t left_n, right_n;
    if (i == 0) begin : g_first
      assign left_n = entry_cell;
    end else begin : g_mid_l
      assign left_n = cells[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_n = empty_cell;
    end else begin : g_mid_r
      assign right_n = cells[i+1];
    end
    sktb_cell #(
      .PARITY (1'(i % 2))
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (cell_ctl),
      .left  (left_n),
      .right (right_n),
      .q     (cells[i])
    );
  end

  sktb_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = $signed(ram_rdata);
  assign cnt_eff  = set_closed ? '0 : entry_count;
  assign diff     = high - low;
  assign mid_sum  = low + (diff >>> 1);
  assign mid_calc = mid_sum[ADDR_W-1:0];
  assign mid_s    = $signed({{(SW-ADDR_W){1'b0}}, mid});
  assign mid_ext  = {{POS_W{1'b0}}, mid};

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    set_closed_next  = set_closed;
    step_next        = step;
    low_next         = low;
    high_next        = high;
    mid_next         = mid;
    search_key_next  = search_key;
    found_next       = found_q;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    rsp_next         = rsp;
    req_ready        = 1'b0;
    cell_ctl.op      = CELL_HOLD;
    cell_ctl.phase   = step[0];
    ram_we           = 1'b0;
    ram_waddr        = cnt_eff[ADDR_W-1:0];
    ram_wdata        = req.key;
    ram_raddr        = mid_calc;

    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.mode == MODE_LOAD) begin
            set_closed_next  = 1'b0;
            entry_count_next = cnt_eff;
            if (cnt_eff < DEPTH_C) begin
              ram_we           = 1'b1;
              cell_ctl.op      = CELL_SHIFT_IN;
              entry_count_next = cnt_eff + CNT_W'(1);
            end
            if (req.last) begin
              set_closed_next = 1'b1;
              step_next       = '0;
              state_next      = ST_SORT;
            end
          end else begin
            search_key_next = req.key;
            low_next        = '0;
            high_next       = $signed({1'b0, entry_count}) - SW'(1);
            found_next      = 1'b0;
            state_next      = (entry_count == '0) ? ST_DONE : ST_PROBE;
          end
        end
      end
      ST_SORT: begin
        cell_ctl.op = CELL_SORT;
        step_next   = step + CNT_W'(1);
        if (step == entry_count - CNT_W'(1)) begin
          step_next  = '0;
          state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        // Drain the sorted row from cell 0 into the key memory.
        ram_we      = 1'b1;
        ram_waddr   = step[ADDR_W-1:0];
        ram_wdata   = cells[0].key;
        cell_ctl.op = CELL_SHIFT_OUT;
        step_next   = step + CNT_W'(1);
        if (step == entry_count - CNT_W'(1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_PROBE: begin
        mid_next   = mid_calc;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (rd_key == search_key) begin
          found_next = 1'b1;
          state_next = ST_DONE;
        end else if (rd_key < search_key) begin
          low_next   = mid_s + SW'(1);
          state_next = (mid_s + SW'(1) > high) ? ST_DONE : ST_PROBE;
        end else begin
          high_next  = mid_s - SW'(1);
          state_next = (low > mid_s - SW'(1)) ? ST_DONE : ST_PROBE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next    = 1'b1;
          rsp_next.found    = found_q;
          rsp_next.position = found_q ? mid_ext[POS_W-1:0] : '0;
          state_next        = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      set_closed  <= 1'b1;
      step        <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      set_closed  <= set_closed_next;
      step        <= step_next;
      rsp_valid   <= rsp_valid_next;
    end
    low        <= low_next;
    high       <= high_next;
    mid        <= mid_next;
    search_key <= search_key_next;
    found_q    <= found_next;
    rsp        <= rsp_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count above table depth");

  a_probe_window: assert property (@(posedge clk) disable iff (rst)
    state == ST_PROBE |-> (low <= high) && (low >= 0)
      && (high < $signed({1'b0, entry_count})))
    else $error("probe window outside stored keys");

  a_row_drained: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && set_closed |-> !cells[0].valid)
    else $error("cell row not drained after sort");

  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) && !rsp.found |-> rsp.position == '0)
    else $error("miss reported with nonzero position");

endmodule
